FILE: sv/spisd_pkg.sv
`default_nettype none

package spisd_pkg;

	localparam int unsigned SECTOR_BYTES     = 512;
	localparam int unsigned SECTOR_COUNT_DEF = 64;

	// byte index inside a sector and the sector number carried by the byte address
	localparam int unsigned IDX_W        = 9;
	localparam int unsigned SECTOR_NUM_W = 32 - IDX_W;

	// position inside a data block: start token, payload, two crc bytes
	localparam int unsigned BPOS_W = 10;
	localparam logic [BPOS_W-1:0] BLOCK_LEN     = BPOS_W'(SECTOR_BYTES + 3);
	localparam logic [BPOS_W-1:0] REG_BLOCK_LEN = BPOS_W'(19);
	localparam logic [BPOS_W-1:0] DATA_LAST     = BPOS_W'(SECTOR_BYTES);

	localparam logic [2:0] CMD_LAST_IDX = 3'd5;

	localparam logic [7:0] CMD_MASK      = 8'hC0;
	localparam logic [7:0] CMD_PREFIX    = 8'h40;
	localparam logic [5:0] CMD_INDEX     = 6'h3F;
	localparam logic [7:0] START_TOKEN   = 8'hFE;
	localparam logic [7:0] R1_IDLE       = 8'h01;
	localparam logic [7:0] R1_READY      = 8'h00;
	localparam logic [7:0] R1_ILLEGAL    = 8'h04;
	localparam logic [7:0] DATA_ACCEPTED = 8'hE5;
	localparam logic [15:0] IDLE_WORD    = 16'hFFFF;

	localparam logic [5:0] CMD_GO_IDLE      = 6'd0;
	localparam logic [5:0] CMD_SEND_OP_COND = 6'd1;
	localparam logic [5:0] CMD_SEND_CSD     = 6'd9;
	localparam logic [5:0] CMD_SEND_CID     = 6'd10;
	localparam logic [5:0] CMD_SEND_STATUS  = 6'd13;
	localparam logic [5:0] CMD_READ_SINGLE  = 6'd17;
	localparam logic [5:0] CMD_WRITE_SINGLE = 6'd24;

	typedef enum logic [1:0] {
		PH_CMD,
		PH_REPLY,
		PH_GETDATA,
		PH_SENDDATA
	} phase_t;

	typedef struct packed {
		logic [15:0] host_word;
		logic        word_mode;
	} req_item_t;

	typedef struct packed {
		logic [15:0] card_word;
	} resp_item_t;

endpackage

`default_nettype wire

FILE: sv/spisd_req_if.sv
`default_nettype none

interface spisd_req_if;
	logic                  valid;
	logic                  ready;
	spisd_pkg::req_item_t  item;

	modport source (output valid, output item, input ready);
	modport sink (input valid, input item, output ready);
endinterface

`default_nettype wire

FILE: sv/spisd_resp_if.sv
`default_nettype none

interface spisd_resp_if;
	logic                  valid;
	logic                  ready;
	spisd_pkg::resp_item_t item;

	modport source (output valid, output item, input ready);
	modport sink (input valid, input item, output ready);
endinterface

`default_nettype wire

FILE: sv/spisd_ram.sv
`default_nettype none

module spisd_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 512
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]              rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rd_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_q <= mem[rd_addr];
	end

	assign rd_data = rd_q;

endmodule

`default_nettype wire

FILE: sv/spi_sd_card_responder.sv
`default_nettype none

// channel | dir | payload                         | handshake
// req     | in  | host_word[15:0], word_mode      | valid/ready
// resp    | out | card_word[15:0]                 | valid/ready
//
// a 16-bit exchange is done as two byte exchanges (high byte, then low byte)
// dispatch of a read or write command (17 or 24) stalls while a reciprocal
// multiply reduces the sector number modulo SECTOR_COUNT
// after reset all SECTOR_COUNT * 512 bytes of the sector store are swept to zero, ready low
// sector reads are prefetched from the store's registered port one exchange ahead
// the result register lets a new request in while a result still waits on resp.ready

module spi_sd_card_responder #(
	parameter int unsigned SECTOR_COUNT = spisd_pkg::SECTOR_COUNT_DEF
) (
	input wire logic     clk,
	input wire logic     arst_n,
	spisd_req_if.sink    req,
	spisd_resp_if.source resp
);

	localparam int unsigned STORE_DEPTH = SECTOR_COUNT * spisd_pkg::SECTOR_BYTES;
	localparam int unsigned ADDR_W      = $clog2(STORE_DEPTH);
	localparam int unsigned SEC_W       = (SECTOR_COUNT > 1) ? $clog2(SECTOR_COUNT) : 1;
	localparam int unsigned MOD_CNT_W   = 2;
	localparam int unsigned BPOS_W      = spisd_pkg::BPOS_W;
	localparam int unsigned IDX_W       = spisd_pkg::IDX_W;
	localparam int unsigned NUM_W       = spisd_pkg::SECTOR_NUM_W;
	localparam int unsigned RECIP_SH    = NUM_W + 1;
	localparam int unsigned RECIP_W     = RECIP_SH + 1;
	localparam int unsigned PROD_W      = NUM_W + RECIP_W;
	localparam logic [SEC_W:0]      COUNT_V  = (SEC_W + 1)'(SECTOR_COUNT);
	localparam logic [NUM_W-1:0]    COUNT_N  = NUM_W'(SECTOR_COUNT);
	localparam logic [RECIP_W-1:0]  RECIP    = RECIP_W'((64'd1 << RECIP_SH) / SECTOR_COUNT);
	localparam logic [ADDR_W-1:0]   CLR_LAST = ADDR_W'(STORE_DEPTH - 1);
	localparam logic [MOD_CNT_W-1:0] MOD_STEPS = MOD_CNT_W'(3);

	// input and result registers
	logic                  valid_s1;
	logic                  half_s1;
	spisd_pkg::req_item_t  item_s1;
	logic                  out_valid_q;
	logic [15:0]           out_word_q;
	logic [7:0]            hi_byte_q;

	// protocol state
	spisd_pkg::phase_t     phase_q, phase_d;
	spisd_pkg::phase_t     after_q, after_d;
	logic [2:0]            cnt_q, cnt_d;
	logic [7:0]            cmd_q [5];
	logic [7:0]            reply_first_q, reply_first_d;
	logic [1:0]            rpos_q, rpos_d;
	logic [1:0]            rlen_q, rlen_d;
	logic [BPOS_W-1:0]     bpos_q, bpos_d;
	logic                  blk_sector_q, blk_sector_d;
	logic [SEC_W-1:0]      sector_q, sector_d;

	// sector remainder unit
	logic                  mod_busy_q;
	logic [MOD_CNT_W-1:0]  mod_cnt_q;
	logic [NUM_W-1:0]      mod_x_q, mod_quot_q, mod_diff;
	logic [SEC_W:0]        mod_rem_q, mod_fix;
	logic [PROD_W-1:0]     mod_prod;
	logic                  mod_start, mod_done;

	// store clearing sweep
	logic                  clr_busy_q;
	logic [ADDR_W-1:0]     clr_addr_q;

	logic                  out_free, step_last, step_en, take_req, cmd_wr;
	logic [7:0]            cur_byte;
	logic [15:0]           byte_res, result_word;
	logic [BPOS_W-1:0]     blk_len, bpos_m1, rd_pos_m1;
	logic                  st_wr_en;
	logic [ADDR_W-1:0]     st_wr_addr, st_rd_addr;
	logic [7:0]            st_wr_data, st_rd_data;

	assign out_free  = !out_valid_q || resp.ready;
	assign step_last = !item_s1.word_mode || half_s1;
	assign step_en   = valid_s1 && !clr_busy_q && !mod_busy_q && (!step_last || out_free);
	assign take_req  = !clr_busy_q && (!valid_s1 || (step_en && step_last));

	assign req.ready  = take_req;
	assign resp.valid = out_valid_q;
	assign resp.item.card_word = out_word_q;

	assign cur_byte = (item_s1.word_mode && !half_s1) ? item_s1.host_word[15:8]
	                                                  : item_s1.host_word[7:0];
	assign blk_len  = blk_sector_q ? spisd_pkg::BLOCK_LEN : spisd_pkg::REG_BLOCK_LEN;

	// next state of the byte exchange
	always_comb begin
		phase_d       = phase_q;
		after_d       = after_q;
		cnt_d         = cnt_q;
		reply_first_d = reply_first_q;
		rpos_d        = rpos_q;
		rlen_d        = rlen_q;
		bpos_d        = bpos_q;
		blk_sector_d  = blk_sector_q;
		cmd_wr        = 1'b0;
		mod_start     = 1'b0;
		if (step_en) begin
			case (phase_q)
				spisd_pkg::PH_CMD: begin
					if (cnt_q != 3'd0
					    || (cur_byte & spisd_pkg::CMD_MASK) == spisd_pkg::CMD_PREFIX) begin
						if (cnt_q == spisd_pkg::CMD_LAST_IDX) begin
							cnt_d         = 3'd0;
							after_d       = spisd_pkg::PH_CMD;
							bpos_d        = '0;
							blk_sector_d  = 1'b0;
							rpos_d        = 2'd0;
							rlen_d        = 2'd1;
							phase_d       = spisd_pkg::PH_REPLY;
							reply_first_d = spisd_pkg::R1_READY;
							case (cmd_q[0][5:0] & spisd_pkg::CMD_INDEX)
								spisd_pkg::CMD_GO_IDLE: begin
									reply_first_d = spisd_pkg::R1_IDLE;
								end
								spisd_pkg::CMD_SEND_OP_COND: begin
									reply_first_d = spisd_pkg::R1_READY;
								end
								spisd_pkg::CMD_SEND_CSD, spisd_pkg::CMD_SEND_CID: begin
									after_d = spisd_pkg::PH_SENDDATA;
								end
								spisd_pkg::CMD_SEND_STATUS: begin
									rlen_d = 2'd2;
								end
								spisd_pkg::CMD_READ_SINGLE: begin
									blk_sector_d = 1'b1;
									after_d      = spisd_pkg::PH_SENDDATA;
									mod_start    = 1'b1;
								end
								spisd_pkg::CMD_WRITE_SINGLE: begin
									after_d   = spisd_pkg::PH_GETDATA;
									mod_start = 1'b1;
								end
								default: begin
									reply_first_d = spisd_pkg::R1_ILLEGAL;
								end
							endcase
						end else begin
							cmd_wr = 1'b1;
							cnt_d  = cnt_q + 3'd1;
						end
					end
				end
				spisd_pkg::PH_REPLY: begin
					rpos_d = rpos_q + 2'd1;
					if (rpos_d >= rlen_q) begin
						phase_d = after_q;
					end
				end
				spisd_pkg::PH_GETDATA: begin
					if (bpos_q != '0 || cur_byte == spisd_pkg::START_TOKEN) begin
						if (bpos_q == spisd_pkg::BLOCK_LEN - BPOS_W'(1)) begin
							bpos_d        = '0;
							after_d       = spisd_pkg::PH_CMD;
							reply_first_d = spisd_pkg::DATA_ACCEPTED;
							rlen_d        = 2'd1;
							rpos_d        = 2'd0;
							phase_d       = spisd_pkg::PH_REPLY;
						end else begin
							bpos_d = bpos_q + BPOS_W'(1);
						end
					end
				end
				default: begin
					bpos_d = bpos_q + BPOS_W'(1);
					if (bpos_d >= blk_len) begin
						phase_d = spisd_pkg::PH_CMD;
					end
				end
			endcase
		end
	end

	// byte sent back for the current exchange
	always_comb begin
		byte_res = spisd_pkg::IDLE_WORD;
		case (phase_q)
			spisd_pkg::PH_REPLY: begin
				byte_res = {8'h00, (rpos_q == 2'd0) ? reply_first_q : 8'h00};
			end
			spisd_pkg::PH_SENDDATA: begin
				if (bpos_q == '0) begin
					byte_res = {8'h00, spisd_pkg::START_TOKEN};
				end else if (blk_sector_q && bpos_q <= spisd_pkg::DATA_LAST) begin
					byte_res = {8'h00, st_rd_data};
				end else begin
					byte_res = 16'h0000;
				end
			end
			default: begin
				byte_res = spisd_pkg::IDLE_WORD;
			end
		endcase
	end

	assign result_word = item_s1.word_mode ? {hi_byte_q, byte_res[7:0]} : byte_res;

	// sector number modulo SECTOR_COUNT: reciprocal estimate, back-multiply,
	// then one correcting subtract as the estimate may be one low
	assign mod_prod = PROD_W'(mod_x_q) * PROD_W'(RECIP);
	assign mod_diff = mod_x_q - mod_quot_q * COUNT_N;
	assign mod_fix  = (mod_rem_q >= COUNT_V) ? (mod_rem_q - COUNT_V) : mod_rem_q;
	assign mod_done = mod_busy_q && mod_cnt_q == MOD_CNT_W'(1);
	assign sector_d = mod_done ? mod_fix[SEC_W-1:0] : sector_q;

	// store ports: payload bytes land at their place as they come in
	assign bpos_m1    = bpos_q - BPOS_W'(1);
	assign rd_pos_m1  = bpos_d - BPOS_W'(1);
	assign st_wr_en   = clr_busy_q
	                    || (step_en && phase_q == spisd_pkg::PH_GETDATA && bpos_q != '0
	                        && bpos_q <= spisd_pkg::DATA_LAST);
	assign st_wr_addr = clr_busy_q ? clr_addr_q
	                               : ADDR_W'({sector_q, bpos_m1[IDX_W-1:0]});
	assign st_wr_data = clr_busy_q ? 8'h00 : cur_byte;
	// prefetch the byte for the position the next exchange will see
	assign st_rd_addr = ADDR_W'({sector_d, rd_pos_m1[IDX_W-1:0]});

	spisd_ram #(
		.WIDTH (8),
		.DEPTH (STORE_DEPTH)
	) u_store (
		.clk     (clk),
		.wr_en   (st_wr_en),
		.wr_addr (st_wr_addr),
		.wr_data (st_wr_data),
		.rd_addr (st_rd_addr),
		.rd_data (st_rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1     <= 1'b0;
			half_s1      <= 1'b0;
			out_valid_q  <= 1'b0;
			phase_q      <= spisd_pkg::PH_CMD;
			after_q      <= spisd_pkg::PH_CMD;
			cnt_q        <= 3'd0;
			rpos_q       <= 2'd0;
			rlen_q       <= 2'd0;
			bpos_q       <= '0;
			blk_sector_q <= 1'b0;
			sector_q     <= '0;
			mod_busy_q   <= 1'b0;
			mod_cnt_q    <= '0;
			clr_busy_q   <= 1'b1;
			clr_addr_q   <= '0;
		end else begin
			if (take_req && req.valid) begin
				valid_s1 <= 1'b1;
				half_s1  <= 1'b0;
			end else if (step_en) begin
				if (step_last) begin
					valid_s1 <= 1'b0;
				end else begin
					half_s1 <= 1'b1;
				end
			end

			if (step_en && step_last) begin
				out_valid_q <= 1'b1;
			end else if (resp.ready) begin
				out_valid_q <= 1'b0;
			end

			phase_q      <= phase_d;
			after_q      <= after_d;
			cnt_q        <= cnt_d;
			rpos_q       <= rpos_d;
			rlen_q       <= rlen_d;
			bpos_q       <= bpos_d;
			blk_sector_q <= blk_sector_d;
			sector_q     <= sector_d;

			if (mod_start) begin
				mod_busy_q <= 1'b1;
				mod_cnt_q  <= MOD_STEPS;
			end else if (mod_busy_q) begin
				mod_cnt_q <= mod_cnt_q - MOD_CNT_W'(1);
				if (mod_done) begin
					mod_busy_q <= 1'b0;
				end
			end

			if (clr_busy_q) begin
				if (clr_addr_q == CLR_LAST) begin
					clr_busy_q <= 1'b0;
				end else begin
					clr_addr_q <= clr_addr_q + ADDR_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take_req && req.valid) begin
			item_s1 <= req.item;
		end
		if (step_en && !step_last) begin
			hi_byte_q <= byte_res[7:0];
		end
		if (step_en && step_last) begin
			out_word_q <= result_word;
		end
		if (cmd_wr) begin
			cmd_q[cnt_q] <= cur_byte;
		end
		reply_first_q <= reply_first_d;
		if (mod_start) begin
			mod_x_q <= {cmd_q[1], cmd_q[2], cmd_q[3][7:1]};
		end
		mod_quot_q <= mod_prod[RECIP_SH +: NUM_W];
		mod_rem_q  <= mod_diff[SEC_W:0];
	end

endmodule

`default_nettype wire

FILE: sv/spisd_checker.sv
`default_nettype none

module spisd_sva (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        req_valid,
	input wire logic        req_ready,
	input wire logic        resp_valid,
	input wire logic        resp_ready,
	input wire logic [15:0] resp_word
);

	logic [1:0] pending_q;
	logic       req_fire, resp_fire;

	assign req_fire  = req_valid && req_ready;
	assign resp_fire = resp_valid && resp_ready;

	// requests taken but not yet answered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= 2'd0;
		end else begin
			pending_q <= pending_q + {1'b0, req_fire} - {1'b0, resp_fire};
		end
	end

	a_resp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		resp_valid && !resp_ready |=> resp_valid && $stable(resp_word))
		else $error("result dropped or changed while stalled");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		resp_fire |-> pending_q != 2'd0)
		else $error("result delivered with no request outstanding");

	a_depth: assert property (@(posedge clk) disable iff (!arst_n)
		pending_q <= 2'd2)
		else $error("more requests in flight than the block can hold");

	a_clear_after_reset: assert property (@(posedge clk) disable iff (!arst_n)
		!$past(arst_n) |-> !req_ready)
		else $error("request taken before the store sweep");

endmodule

bind spi_sd_card_responder spisd_sva u_spisd_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.req_valid  (req.valid),
	.req_ready  (req.ready),
	.resp_valid (resp.valid),
	.resp_ready (resp.ready),
	.resp_word  (resp.item.card_word)
);

`default_nettype wire

FILE: sim/spisd_checker.sv
`timescale 1ns / 100ps

module spisd_checker
	import spisd_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       req_valid,
	input  logic       req_ready,
	input  req_item_t  req_item,
	input  logic       resp_valid,
	input  logic       resp_ready,
	input  resp_item_t resp_item,
	output int         errors,
	output int         outstanding
);

	localparam int unsigned STORE_BYTES = SECTOR_COUNT_DEF * SECTOR_BYTES;

	// card state as the host should see it
	phase_t      cur_phase;
	phase_t      after_phase;
	logic [7:0]  frame [6];
	logic [2:0]  frame_cnt;
	logic [7:0]  r1_buf [2];
	logic [1:0]  r1_pos;
	logic [1:0]  r1_len;
	logic [7:0]  blk [SECTOR_BYTES + 3];
	logic [9:0]  blk_pos;
	logic [9:0]  blk_len;
	int unsigned sector;
	logic [7:0]  card_store [STORE_BYTES];

	resp_item_t  expected_words [$];

	initial begin
		errors      = 0;
		outstanding = 0;
		cur_phase   = PH_CMD;
		after_phase = PH_CMD;
		frame_cnt   = '0;
		r1_pos      = '0;
		r1_len      = '0;
		blk_pos     = '0;
		blk_len     = '0;
		sector      = 0;
		for (int i = 0; i < 6; i++) frame[i] = '0;
		for (int i = 0; i < 2; i++) r1_buf[i] = '0;
		for (int i = 0; i < SECTOR_BYTES + 3; i++) blk[i] = '0;
		for (int i = 0; i < STORE_BYTES; i++) card_store[i] = '0;
	end

	function automatic void load_reply(input logic [7:0] first, input logic [1:0] len);
		r1_buf[0] = first;
		r1_buf[1] = '0;
		r1_len    = len;
		r1_pos    = '0;
		cur_phase = PH_REPLY;
	endfunction

	function automatic int unsigned frame_sector();
		logic [31:0] addr;
		addr = {frame[1], frame[2], frame[3], frame[4]};
		return (addr / SECTOR_BYTES) % SECTOR_COUNT_DEF;
	endfunction

	function automatic void run_command();
		logic [5:0] code;
		code        = frame[0][5:0] & CMD_INDEX;
		frame_cnt   = '0;
		after_phase = PH_CMD;
		blk_pos     = '0;
		blk_len     = '0;
		case (code)
			CMD_GO_IDLE: load_reply(R1_IDLE, 2'd1);
			CMD_SEND_OP_COND: load_reply(R1_READY, 2'd1);
			CMD_SEND_CSD, CMD_SEND_CID: begin
				load_reply(R1_READY, 2'd1);
				for (int i = 0; i < REG_BLOCK_LEN; i++) blk[i] = '0;
				blk[0]      = START_TOKEN;
				blk_len     = REG_BLOCK_LEN;
				after_phase = PH_SENDDATA;
			end
			CMD_SEND_STATUS: load_reply(R1_READY, 2'd2);
			CMD_READ_SINGLE: begin
				load_reply(R1_READY, 2'd1);
				sector = frame_sector();
				blk[0] = START_TOKEN;
				for (int i = 0; i < SECTOR_BYTES; i++)
					blk[i + 1] = card_store[sector * SECTOR_BYTES + i];
				blk[SECTOR_BYTES + 1] = '0;
				blk[SECTOR_BYTES + 2] = '0;
				blk_len     = BLOCK_LEN;
				after_phase = PH_SENDDATA;
			end
			CMD_WRITE_SINGLE: begin
				load_reply(R1_READY, 2'd1);
				sector      = frame_sector();
				blk_len     = BLOCK_LEN;
				after_phase = PH_GETDATA;
			end
			default: load_reply(R1_ILLEGAL, 2'd1);
		endcase
	endfunction

	function automatic logic [15:0] card_exchange(input logic [7:0] b);
		logic [15:0] r;
		r = IDLE_WORD;
		case (cur_phase)
			PH_CMD: begin
				// outside a frame only a 01xxxxxx byte opens one
				if (frame_cnt != 0 || (b & CMD_MASK) == CMD_PREFIX) begin
					frame[frame_cnt] = b;
					frame_cnt++;
					if (frame_cnt > CMD_LAST_IDX) run_command();
				end
			end
			PH_REPLY: begin
				r = {8'h00, r1_buf[r1_pos[0]]};
				r1_pos++;
				if (r1_pos >= r1_len) cur_phase = after_phase;
			end
			PH_GETDATA: begin
				// bytes before the start token are dropped
				if (blk_pos != 0 || b == START_TOKEN) begin
					if (blk_pos < BLOCK_LEN) blk[blk_pos] = b;
					blk_pos++;
					if (blk_pos >= blk_len) begin
						for (int i = 0; i < SECTOR_BYTES; i++)
							card_store[sector * SECTOR_BYTES + i] = blk[i + 1];
						blk_pos     = '0;
						after_phase = PH_CMD;
						load_reply(DATA_ACCEPTED, 2'd1);
					end
				end
			end
			default: begin
				r = (blk_pos < BLOCK_LEN) ? {8'h00, blk[blk_pos]} : 16'h0000;
				blk_pos++;
				if (blk_pos >= blk_len) cur_phase = PH_CMD;
			end
		endcase
		return r;
	endfunction

	// a word request is two byte exchanges, high byte first, low bytes packed
	function automatic logic [15:0] predict_card_word(input req_item_t it);
		logic [15:0] hi;
		logic [15:0] lo;
		if (it.word_mode) begin
			hi = card_exchange(it.host_word[15:8]);
			lo = card_exchange(it.host_word[7:0]);
			return {hi[7:0], lo[7:0]};
		end
		return card_exchange(it.host_word[7:0]);
	endfunction

	always @(posedge clk) begin : watch
		resp_item_t want;
		resp_item_t got_exp;
		if (arst_n) begin
			if (req_valid && req_ready) begin
				got_exp.card_word = predict_card_word(req_item);
				expected_words.push_back(got_exp);
			end
			if (resp_valid && resp_ready) begin
				if (expected_words.size() == 0) begin
					$error("card_word: expected none, actual %04h", resp_item.card_word);
					errors++;
				end else begin
					want = expected_words.pop_front();
					if (resp_item.card_word !== want.card_word) begin
						$error("card_word: expected %04h, actual %04h",
							want.card_word, resp_item.card_word);
						errors++;
					end
				end
			end
			outstanding = expected_words.size();
		end
	end

endmodule

FILE: sim/testbench.sv
`timescale 1ns / 100ps

module testbench;
	import spisd_pkg::*;

	localparam int TOTAL_ITEMS = 1550;

	typedef enum {RX_OPEN, RX_COIN, RX_PERIODIC, RX_CHOKE} rx_mode_t;
	typedef enum {
		SEQ_SHORT, SEQ_ILLEGAL, SEQ_REGREAD, SEQ_NOISE, SEQ_WRITE, SEQ_READ, SEQ_CUT
	} seq_kind_t;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;
	int   errors;
	int   outstanding;

	int          burst_left = 0;
	int          sent_items = 0;
	logic [7:0]  tx_bytes [$];
	int unsigned written_sectors [$];

	spisd_req_if  req_ch ();
	spisd_resp_if resp_ch ();

	spi_sd_card_responder #(
		.SECTOR_COUNT(SECTOR_COUNT_DEF)
	) u_dut (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req_ch),
		.resp  (resp_ch)
	);

	spisd_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_ch.valid),
		.req_ready  (req_ch.ready),
		.req_item   (req_ch.item),
		.resp_valid (resp_ch.valid),
		.resp_ready (resp_ch.ready),
		.resp_item  (resp_ch.item),
		.errors     (errors),
		.outstanding(outstanding)
	);

	always #2 clk = ~clk;

	initial begin
		#2_000_000;
		$display("testbench: done, errors");
		$finish;
	end

	// response side stalls on a pattern that is picked anew after each run of random length
	initial begin : receiver
		rx_mode_t rx_mode;
		int       left;
		int       tick;
		resp_ch.ready = 1'b0;
		rx_mode       = RX_OPEN;
		left          = 0;
		tick          = 0;
		forever begin
			@(negedge clk);
			if (left == 0) begin
				rx_mode = rx_mode_t'($urandom_range(0, 3));
				left    = $urandom_range(50, 400);
			end
			left--;
			tick++;
			case (rx_mode)
				RX_OPEN:     resp_ch.ready <= 1'b1;
				RX_COIN:     resp_ch.ready <= 1'($urandom_range(0, 1));
				RX_PERIODIC: resp_ch.ready <= (tick % 7) < 4;
				default:     resp_ch.ready <= ($urandom_range(0, 7) == 0);
			endcase
		end
	end

	task automatic push_request(input logic [15:0] w, input logic m);
		if (burst_left == 0) begin
			req_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(negedge clk);
			burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
				: $urandom_range(1, 12);
		end
		burst_left--;
		req_ch.valid <= 1'b1;
		req_ch.item  <= '{host_word: w, word_mode: m};
		do @(posedge clk); while (!req_ch.ready);
		@(negedge clk);
		sent_items++;
	endtask

	task automatic drain_results();
		req_ch.valid <= 1'b0;
		do @(negedge clk); while (outstanding != 0);
	endtask

	// byte-mode requests carry random upper bits, which the card ignores
	task automatic flush_bytes(input int word_pct);
		logic [15:0] w;
		while (tx_bytes.size() != 0) begin
			if (tx_bytes.size() >= 2 && $urandom_range(0, 99) < word_pct) begin
				w[15:8] = tx_bytes.pop_front();
				w[7:0]  = tx_bytes.pop_front();
				push_request(w, 1'b1);
			end else begin
				w[15:8] = 8'($urandom);
				w[7:0]  = tx_bytes.pop_front();
				push_request(w, 1'b0);
			end
		end
	endtask

	function automatic void queue_frame(input logic [5:0] code, input logic [31:0] addr);
		tx_bytes.push_back(CMD_PREFIX | {2'b00, code});
		tx_bytes.push_back(addr[31:24]);
		tx_bytes.push_back(addr[23:16]);
		tx_bytes.push_back(addr[15:8]);
		tx_bytes.push_back(addr[7:0]);
		tx_bytes.push_back(8'($urandom));
	endfunction

	function automatic void queue_filler(input int n);
		for (int i = 0; i < n; i++) tx_bytes.push_back(8'($urandom));
	endfunction

	initial begin : stimulus
		seq_kind_t   kind;
		int          seq_no;
		int          pick;
		int          cut_at;
		logic [5:0]  code;
		logic [7:0]  b;
		logic [31:0] addr;
		int unsigned s;
		int          n_short;
		int          n_illegal;
		int          n_regread;
		int          n_noise;
		int          n_write;
		int          n_read;
		int          n_cut;

		seq_no    = 0;
		n_short   = 0;
		n_illegal = 0;
		n_regread = 0;
		n_noise   = 0;
		n_write   = 0;
		n_read    = 0;
		n_cut     = 0;
		req_ch.valid = 1'b0;
		req_ch.item  = '0;

		repeat (3) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// noise while idle, both widths, field extremes
		push_request(16'hFFFF, 1'b0);
		push_request(16'h0080, 1'b0);
		push_request(16'hFFFF, 1'b1);
		// go idle as words, then one reply byte in the high half
		push_request(16'h4000, 1'b1);
		push_request(16'h0000, 1'b1);
		push_request(16'h0095, 1'b1);
		push_request(16'hFFFF, 1'b1);
		// op cond, reply read as a byte
		push_request(16'h4100, 1'b1);
		push_request(16'h0000, 1'b1);
		push_request(16'h00FF, 1'b1);
		push_request(16'h5AFF, 1'b0);
		// status: two reply bytes in one word
		push_request(16'h4D00, 1'b1);
		push_request(16'h0000, 1'b1);
		push_request(16'h0000, 1'b1);
		push_request(16'hFFFF, 1'b1);
		// highest command index is illegal
		push_request(16'h7FFF, 1'b1);
		push_request(16'hFFFF, 1'b1);
		push_request(16'hFFFF, 1'b1);
		push_request(16'h0000, 1'b0);
		// frame opened by the low half of a word
		push_request(16'hFF40, 1'b1);
		push_request(16'h0000, 1'b1);
		push_request(16'h0000, 1'b1);
		push_request(16'hA501, 1'b0);
		push_request(16'h00FF, 1'b0);
		drain_results();

		while (sent_items < TOTAL_ITEMS) begin
			seq_no++;
			if (seq_no % 6 == 0) begin
				kind = (written_sectors.size() == 0) ? SEQ_WRITE
					: seq_kind_t'($urandom_range(SEQ_WRITE, SEQ_CUT));
			end else begin
				pick = $urandom_range(0, 99);
				if (pick < 40)      kind = SEQ_SHORT;
				else if (pick < 55) kind = SEQ_ILLEGAL;
				else if (pick < 75) kind = SEQ_REGREAD;
				else if (pick < 92) kind = SEQ_NOISE;
				else if (pick < 96) kind = SEQ_WRITE;
				else                kind = SEQ_READ;
			end
			if (kind == SEQ_READ && written_sectors.size() == 0) kind = SEQ_WRITE;

			case (kind)
				SEQ_SHORT: begin
					pick = $urandom_range(0, 2);
					code = (pick == 0) ? CMD_GO_IDLE
						: (pick == 1) ? CMD_SEND_OP_COND : CMD_SEND_STATUS;
					queue_frame(code, $urandom);
					queue_filler((code == CMD_SEND_STATUS) ? 2 : 1);
					flush_bytes(50);
					n_short++;
				end
				SEQ_ILLEGAL: begin
					do code = 6'($urandom);
					while (code == CMD_GO_IDLE || code == CMD_SEND_OP_COND
						|| code == CMD_SEND_CSD || code == CMD_SEND_CID
						|| code == CMD_SEND_STATUS || code == CMD_READ_SINGLE
						|| code == CMD_WRITE_SINGLE);
					queue_frame(code, $urandom);
					queue_filler(1);
					flush_bytes(50);
					n_illegal++;
				end
				SEQ_REGREAD: begin
					code = $urandom_range(0, 1) ? CMD_SEND_CSD : CMD_SEND_CID;
					queue_frame(code, $urandom);
					queue_filler(1 + REG_BLOCK_LEN);
					flush_bytes(60);
					n_regread++;
				end
				SEQ_NOISE: begin
					repeat ($urandom_range(1, 5)) begin
						b = 8'($urandom);
						if ((b & CMD_MASK) == CMD_PREFIX) b[7] = 1'b1;
						tx_bytes.push_back(b);
					end
					flush_bytes(50);
					n_noise++;
				end
				SEQ_WRITE: begin
					pick = $urandom_range(0, 9);
					addr = (pick == 0) ? 32'h0000_0000 : (pick == 1) ? 32'hFFFF_FFFF : $urandom;
					s    = (addr / SECTOR_BYTES) % SECTOR_COUNT_DEF;
					queue_frame(CMD_WRITE_SINGLE, addr);
					queue_filler(1);
					// junk ahead of the start token
					repeat ($urandom_range(0, 3)) begin
						b = 8'($urandom);
						if (b == START_TOKEN) b = ~b;
						tx_bytes.push_back(b);
					end
					tx_bytes.push_back(START_TOKEN);
					queue_filler(SECTOR_BYTES + 2);
					queue_filler(1);
					written_sectors.push_back(s);
					flush_bytes(85);
					n_write++;
				end
				default: begin
					// read back a written sector most of the time
					if (written_sectors.size() != 0 && $urandom_range(0, 3) != 0)
						s = written_sectors[$urandom_range(0, written_sectors.size() - 1)];
					else
						s = $urandom_range(0, SECTOR_COUNT_DEF - 1);
					addr = $urandom_range(0, (32'h0080_0000 / SECTOR_COUNT_DEF) - 1);
					addr = (addr * SECTOR_COUNT_DEF + s) * SECTOR_BYTES
						+ $urandom_range(0, SECTOR_BYTES - 1);
					queue_frame(CMD_READ_SINGLE, addr);
					if (kind == SEQ_CUT) begin
						// host fires a new command mid-block, the card keeps sending
						cut_at = $urandom_range(0, BLOCK_LEN - 6);
						queue_filler(1 + cut_at);
						queue_frame(6'($urandom), $urandom);
						queue_filler(BLOCK_LEN - cut_at - 6);
						n_cut++;
					end else begin
						queue_filler(1 + BLOCK_LEN);
						n_read++;
					end
					flush_bytes(85);
				end
			endcase

			if ($urandom_range(0, 7) == 0) drain_results();
		end

		req_ch.valid <= 1'b0;
		do @(negedge clk); while (outstanding != 0);
		repeat (64) @(negedge clk);

		$display("testbench: %0d requests; %0d short commands, %0d illegal, %0d csd/cid, %0d noise runs",
			sent_items, n_short, n_illegal, n_regread, n_noise);
		$display("testbench: %0d sector writes, %0d sector reads, %0d reads cut by a command",
			n_write, n_read, n_cut);
		if (errors == 0)
			$display("testbench: done, clean");
		else
			$display("testbench: done, errors");
		$finish;
	end

endmodule
